/* hw/rtl/tcspq_pkg.sv */
// ----------------------------------------------------------------------------
// tcspq_pkg
// Shared sizes, codes and types of the two-class strict priority queue.
// ----------------------------------------------------------------------------
package tcspq_pkg;

    // Queue sizing
    localparam int FIFO_DEPTH = 128;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int TAIL_W     = PTR_W + 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int BYTES_W    = $clog2(FIFO_DEPTH * 65535 + 1);

    // Field widths
    localparam int OP_W     = 2;
    localparam int PROTO_W  = 8;
    localparam int PORT_W   = 16;
    localparam int LEN_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = HANDLE_W + LEN_W;

    // Configuration widths
    localparam int MODE_W = 1;
    localparam int MAXP_W = 8;
    localparam int MAXB_W = 23;
    localparam int CFG_W  = 23;
    localparam int CIDX_W = 2;

    // Compare widths for the admission checks
    localparam int CMP_W = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;
    localparam int SUM_W = ((BYTES_W > MAXB_W) ? BYTES_W : MAXB_W) + 1;

    // Stream packing
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    // IP protocol numbers
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_LIMIT_MODE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_PACKETS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_BYTES   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_HIGH_PORT   = 2'd3;

    // Register reset values
    localparam logic [MODE_W-1:0] RST_LIMIT_MODE  = 1'b0;
    localparam logic [MAXP_W-1:0] RST_MAX_PACKETS = 8'd100;
    localparam logic [MAXB_W-1:0] RST_MAX_BYTES   = 23'd6553500;
    localparam logic [PORT_W-1:0] RST_HIGH_PORT   = 16'd3000;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;
        logic exec;
        logic fetch;
        logic load_out;
    } cmd_t;

endpackage

/* hw/rtl/tcspq_ctrl.sv */
// ----------------------------------------------------------------------------
// tcspq_ctrl
// Sequencer: accepts one word, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module tcspq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              need_fetch,
    output tcspq_pkg::cmd_t   cmd
);
    import tcspq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = need_fetch ? S_FETCH : S_OUT;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // output register free or being drained this cycle
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* hw/rtl/tcspq_datapath.sv */
// ----------------------------------------------------------------------------
// tcspq_datapath
// Config registers, class FIFOs with pointers and byte counts, result regs.
// ----------------------------------------------------------------------------
module tcspq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcspq_pkg::cmd_t                     cmd,
    output logic                                need_fetch,
    input  logic                                cfg_we,
    input  logic [tcspq_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [tcspq_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [tcspq_pkg::OP_W-1:0]          in_op,
    input  logic [tcspq_pkg::PROTO_W-1:0]       in_proto,
    input  logic [tcspq_pkg::PORT_W-1:0]        in_port,
    input  logic [tcspq_pkg::LEN_W-1:0]         in_len,
    input  logic [tcspq_pkg::HANDLE_W-1:0]      in_handle,
    output logic [tcspq_pkg::STATUS_W-1:0]      out_status,
    output logic [tcspq_pkg::HANDLE_W-1:0]      out_handle,
    output logic [tcspq_pkg::LEN_W-1:0]         out_length,
    output logic                                out_high
);
    import tcspq_pkg::*;

    // Configuration
    logic [MODE_W-1:0] limit_mode_reg;
    logic [MAXP_W-1:0] max_packets_reg;
    logic [MAXB_W-1:0] max_bytes_reg;
    logic [PORT_W-1:0] high_port_reg;

    // Latched word
    logic [OP_W-1:0]     op_reg;
    logic [PROTO_W-1:0]  proto_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // Queue state
    logic [PTR_W-1:0]   high_head_reg, high_head_next;
    logic [PTR_W-1:0]   low_head_reg, low_head_next;
    logic [CNT_W-1:0]   high_count_reg, high_count_next;
    logic [CNT_W-1:0]   low_count_reg, low_count_next;
    logic [BYTES_W-1:0] high_bytes_reg, high_bytes_next;
    logic [BYTES_W-1:0] low_bytes_reg, low_bytes_next;

    // Descriptor memories
    logic [ENTRY_W-1:0] high_mem [FIFO_DEPTH];
    logic [ENTRY_W-1:0] low_mem [FIFO_DEPTH];
    logic [ENTRY_W-1:0] high_rd_reg, low_rd_reg;

    // Dequeue bookkeeping between exec and fetch
    logic sel_high_reg, sel_high_next;
    logic take_reg, take_next;

    // Pending result and output register
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [LEN_W-1:0]    res_len_reg, res_len_next;
    logic                res_high_reg, res_high_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_high_reg;

    // Exec-stage decode
    logic               is_deq_or_peek;
    logic               q_empty;
    logic               to_high;
    logic [CNT_W-1:0]   sel_cnt;
    logic [PTR_W-1:0]   sel_head;
    logic [BYTES_W-1:0] sel_bytes;
    logic [SUM_W-1:0]   byte_sum;
    logic [TAIL_W-1:0]  tail_sum;
    logic [PTR_W-1:0]   tail;
    logic               drop;
    logic               admit;
    logic               high_we, low_we;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic [TAIL_W-1:0]  head_inc;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_mode_reg  <= RST_LIMIT_MODE;
            max_packets_reg <= RST_MAX_PACKETS;
            max_bytes_reg   <= RST_MAX_BYTES;
            high_port_reg   <= RST_HIGH_PORT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIMIT_MODE:  limit_mode_reg  <= cfg_wdata[MODE_W-1:0];
                CFG_MAX_PACKETS: max_packets_reg <= cfg_wdata[MAXP_W-1:0];
                CFG_MAX_BYTES:   max_bytes_reg   <= cfg_wdata[MAXB_W-1:0];
                CFG_HIGH_PORT:   high_port_reg   <= cfg_wdata[PORT_W-1:0];
                default:         limit_mode_reg  <= limit_mode_reg;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= in_op;
            proto_reg  <= in_proto;
            port_reg   <= in_port;
            len_reg    <= in_len;
            handle_reg <= in_handle;
        end
    end

    // Classification and admission
    assign is_deq_or_peek = (op_reg == OP_DEQ) || (op_reg == OP_PEEK);
    assign q_empty    = (high_count_reg == '0) && (low_count_reg == '0);
    assign need_fetch = is_deq_or_peek && !q_empty;
    assign to_high    = (proto_reg == PROTO_UDP) && (port_reg == high_port_reg);
    assign sel_cnt    = to_high ? high_count_reg : low_count_reg;
    assign sel_head   = to_high ? high_head_reg : low_head_reg;
    assign sel_bytes  = to_high ? high_bytes_reg : low_bytes_reg;
    assign byte_sum   = SUM_W'(sel_bytes) + SUM_W'(len_reg);
    assign tail_sum   = TAIL_W'(sel_head) + TAIL_W'(sel_cnt);
    assign tail       = (tail_sum >= TAIL_W'(FIFO_DEPTH))
                        ? PTR_W'(tail_sum - TAIL_W'(FIFO_DEPTH)) : PTR_W'(tail_sum);
    assign drop = (sel_cnt >= CNT_W'(FIFO_DEPTH))
                  || ((limit_mode_reg == 1'b0) && (CMP_W'(sel_cnt) >= CMP_W'(max_packets_reg)))
                  || ((limit_mode_reg == 1'b1) && (byte_sum >= SUM_W'(max_bytes_reg)));
    assign admit    = cmd.exec && (op_reg == OP_ENQ) && (proto_reg != PROTO_TCP) && !drop;
    assign high_we  = admit && to_high;
    assign low_we   = admit && !to_high;
    assign wr_entry = {handle_reg, len_reg};

    // Descriptor memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (high_we)
        begin
            high_mem[tail] <= wr_entry;
        end
        if (cmd.exec)
        begin
            high_rd_reg <= high_mem[high_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (low_we)
        begin
            low_mem[tail] <= wr_entry;
        end
        if (cmd.exec)
        begin
            low_rd_reg <= low_mem[low_head_reg];
        end
    end

    assign rd_entry = sel_high_reg ? high_rd_reg : low_rd_reg;
    assign head_inc = TAIL_W'(sel_high_reg ? high_head_reg : low_head_reg) + TAIL_W'(1);

    // Queue state and result update
    always_comb
    begin
        high_head_next  = high_head_reg;
        low_head_next   = low_head_reg;
        high_count_next = high_count_reg;
        low_count_next  = low_count_reg;
        high_bytes_next = high_bytes_reg;
        low_bytes_next  = low_bytes_reg;
        sel_high_next   = sel_high_reg;
        take_next       = take_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_len_next    = res_len_reg;
        res_high_next   = res_high_reg;

        if (cmd.exec)
        begin
            res_handle_next = '0;
            res_len_next    = '0;
            res_high_next   = 1'b0;
            sel_high_next   = (high_count_reg != '0);
            take_next       = (op_reg == OP_DEQ);
            case (op_reg) inside
                OP_ENQ:
                begin
                    if (proto_reg == PROTO_TCP)
                    begin
                        res_status_next = ST_REJECTED;
                    end
                    else if (drop)
                    begin
                        res_status_next = ST_DROPPED;
                    end
                    else
                    begin
                        res_status_next = ST_ACCEPTED;
                    end
                end
                OP_DEQ, OP_PEEK:
                begin
                    res_status_next = q_empty ? ST_EMPTY : ST_SERVED;
                end
                default:
                begin
                    res_status_next = ST_REJECTED;
                end
            endcase
            if (high_we)
            begin
                high_count_next = high_count_reg + CNT_W'(1);
                high_bytes_next = high_bytes_reg + BYTES_W'(len_reg);
            end
            if (low_we)
            begin
                low_count_next = low_count_reg + CNT_W'(1);
                low_bytes_next = low_bytes_reg + BYTES_W'(len_reg);
            end
        end

        // Front descriptor is back from memory
        if (cmd.fetch)
        begin
            res_status_next = ST_SERVED;
            res_handle_next = rd_entry[ENTRY_W-1:LEN_W];
            res_len_next    = rd_entry[LEN_W-1:0];
            res_high_next   = sel_high_reg;
            if (take_reg)
            begin
                if (sel_high_reg)
                begin
                    high_head_next  = (head_inc == TAIL_W'(FIFO_DEPTH))
                                      ? '0 : PTR_W'(head_inc);
                    high_count_next = high_count_reg - CNT_W'(1);
                    high_bytes_next = high_bytes_reg - BYTES_W'(rd_entry[LEN_W-1:0]);
                end
                else
                begin
                    low_head_next  = (head_inc == TAIL_W'(FIFO_DEPTH))
                                     ? '0 : PTR_W'(head_inc);
                    low_count_next = low_count_reg - CNT_W'(1);
                    low_bytes_next = low_bytes_reg - BYTES_W'(rd_entry[LEN_W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_head_reg  <= '0;
            low_head_reg   <= '0;
            high_count_reg <= '0;
            low_count_reg  <= '0;
            high_bytes_reg <= '0;
            low_bytes_reg  <= '0;
        end
        else
        begin
            high_head_reg  <= high_head_next;
            low_head_reg   <= low_head_next;
            high_count_reg <= high_count_next;
            low_count_reg  <= low_count_next;
            high_bytes_reg <= high_bytes_next;
            low_bytes_reg  <= low_bytes_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sel_high_reg   <= sel_high_next;
        take_reg       <= take_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_len_reg    <= res_len_next;
        res_high_reg   <= res_high_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_len_reg    <= res_len_reg;
            out_high_reg   <= res_high_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;
    assign out_length = out_len_reg;
    assign out_high   = out_high_reg;

endmodule

/* hw/rtl/two_class_strict_priority_queue_core.sv */
// Sequence: enqueue, empty and rejected words go from accept through execute to
//   hand-off; served or peeked words add a fetch step for the registered read.
// One word in flight: no new word is accepted until its result is loaded into the
//   output register, and that hand-off waits while the previous result is not taken.
// Reset: queues empty, config registers at their defaults; memories are not cleared,
//   so the block accepts words right after reset.
// ----------------------------------------------------------------------------
// two_class_strict_priority_queue_core
// Descriptor queue with high and low classes, admission limits, strict priority.
// ----------------------------------------------------------------------------
module two_class_strict_priority_queue_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // write port
    input  logic                                cfg_we,
    input  logic [tcspq_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [tcspq_pkg::CFG_W-1:0]         cfg_wdata,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ip_protocol[7:0], udp_dest_port[23:8], packet_length[39:24],
    // packet_handle[55:40]
    input  logic [tcspq_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[1:0]
    input  logic [tcspq_pkg::S_TUSER_W-1:0]     s_tuser,
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_handle[15:0], out_length[31:16]
    output logic [tcspq_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[2:0], out_high[3]
    output logic [tcspq_pkg::M_TUSER_W-1:0]     m_tuser
);
    import tcspq_pkg::*;

    cmd_t                cmd;
    logic                need_fetch;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [LEN_W-1:0]    out_length;
    logic                out_high;

    tcspq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .need_fetch (need_fetch),
        .cmd        (cmd)
    );

    tcspq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .need_fetch (need_fetch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser[OP_W-1:0]),
        .in_proto   (s_tdata[7:0]),
        .in_port    (s_tdata[23:8]),
        .in_len     (s_tdata[39:24]),
        .in_handle  (s_tdata[55:40]),
        .out_status (status),
        .out_handle (out_handle),
        .out_length (out_length),
        .out_high   (out_high)
    );

    // Result packing
    assign m_tdata = {out_length, out_handle};
    assign m_tuser = {out_high, status};

endmodule
